FILE: rtl/met_pkg.sv
// Shared types, constants and the saturation helper of the escape-time unit.
package met_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int FRAC_BITS_DEF   = 28;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int PIXEL_W     = 12;
    localparam int COUNT_W     = 16;
    localparam int WORD_W      = 32;
    localparam int REG_INDEX_W = 3;
    localparam int SAT_IN_W    = 72;

    localparam logic [REG_INDEX_W-1:0] REG_MAX_ITERATION = 3'd0;
    localparam logic [REG_INDEX_W-1:0] REG_ORIGIN_REAL   = 3'd1;
    localparam logic [REG_INDEX_W-1:0] REG_ORIGIN_IMAG   = 3'd2;
    localparam logic [REG_INDEX_W-1:0] REG_STEP_REAL     = 3'd3;
    localparam logic [REG_INDEX_W-1:0] REG_STEP_IMAG     = 3'd4;

    localparam logic        [COUNT_W-1:0] RST_MAX_ITERATION = 16'd256;
    localparam logic signed [WORD_W-1:0]  RST_ORIGIN_REAL   = 32'shC800_0000;
    localparam logic signed [WORD_W-1:0]  RST_ORIGIN_IMAG   = 32'sh0000_0000;
    localparam logic signed [WORD_W-1:0]  RST_STEP_REAL     = 32'sh0000_0000;
    localparam logic signed [WORD_W-1:0]  RST_STEP_IMAG     = 32'sh0000_0000;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_x;
        logic [PIXEL_W-1:0] pixel_y;
    } t_pixel;

    typedef struct packed {
        logic [COUNT_W-1:0] iteration_count;
        logic               inside_set;
    } t_result;

    typedef struct packed {
        logic [REG_INDEX_W-1:0] index;
        logic [WORD_W-1:0]      value;
    } t_cfg_beat;

    typedef struct packed {
        logic        [COUNT_W-1:0] max_iteration;
        logic signed [WORD_W-1:0]  origin_real;
        logic signed [WORD_W-1:0]  origin_imag;
        logic signed [WORD_W-1:0]  step_real;
        logic signed [WORD_W-1:0]  step_imag;
    } t_cfg;

    typedef struct packed {
        logic signed [WORD_W-1:0] c_real;
        logic signed [WORD_W-1:0] c_imag;
        logic                     sat;
    } t_point;

    typedef struct packed {
        logic                     sat;
        logic signed [WORD_W-1:0] value;
    } t_sat;

    function automatic t_sat sat_word(input logic signed [SAT_IN_W-1:0] v);
        t_sat                       r;
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = SAT_IN_W'(WORD_MAX);
        lo = SAT_IN_W'(WORD_MIN);
        if (v > hi) begin
            r.sat   = 1'b1;
            r.value = WORD_MAX;
        end else if (v < lo) begin
            r.sat   = 1'b1;
            r.value = WORD_MIN;
        end else begin
            r.sat   = 1'b0;
            r.value = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/met_chan_if.sv
// Valid/ready channel carrying one payload beat per handshake.
interface met_chan_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/met_regs.sv
// Configuration register file written through the configuration channel.
module met_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  met_pkg::t_cfg_beat  i_beat,
    output met_pkg::t_cfg       o_cfg
);
    import met_pkg::*;

    t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_iteration <= RST_MAX_ITERATION;
            r_cfg.origin_real   <= RST_ORIGIN_REAL;
            r_cfg.origin_imag   <= RST_ORIGIN_IMAG;
            r_cfg.step_real     <= RST_STEP_REAL;
            r_cfg.step_imag     <= RST_STEP_IMAG;
        end else if (i_valid) begin
            unique case (i_beat.index)
                REG_MAX_ITERATION: r_cfg.max_iteration <= i_beat.value[COUNT_W-1:0];
                REG_ORIGIN_REAL:   r_cfg.origin_real   <= i_beat.value;
                REG_ORIGIN_IMAG:   r_cfg.origin_imag   <= i_beat.value;
                REG_STEP_REAL:     r_cfg.step_real     <= i_beat.value;
                REG_STEP_IMAG:     r_cfg.step_imag     <= i_beat.value;
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/met_front.sv
// Front end: takes a pixel beat and forms the saturated point c with its saturation flag.
module met_front #(
    parameter int COORD_BITS = met_pkg::COORD_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  met_pkg::t_pixel i_pixel,
    input  met_pkg::t_cfg   i_cfg,
    output logic            o_push,
    input  logic            i_q_ready,
    output met_pkg::t_point o_point
);
    import met_pkg::*;

    localparam int XW = (COORD_BITS < PIXEL_W) ? COORD_BITS : PIXEL_W;
    localparam int PW = XW + WORD_W + 1;

    logic                 r_valid;
    logic [XW-1:0]        r_x;
    logic [XW-1:0]        r_y;
    logic signed [PW-1:0] prod_re;
    logic signed [PW-1:0] prod_im;
    t_sat                 sat_re;
    t_sat                 sat_im;

    assign o_ready = !r_valid || i_q_ready;
    assign o_push  = r_valid;

    assign prod_re = $signed({1'b0, r_x}) * $signed(i_cfg.step_real);
    assign prod_im = $signed({1'b0, r_y}) * $signed(i_cfg.step_imag);

    always_comb begin
        sat_re = sat_word(SAT_IN_W'(prod_re) + SAT_IN_W'($signed(i_cfg.origin_real)));
        sat_im = sat_word(SAT_IN_W'(prod_im) + SAT_IN_W'($signed(i_cfg.origin_imag)));
        o_point.c_real = sat_re.value;
        o_point.c_imag = sat_im.value;
        o_point.sat    = sat_re.sat || sat_im.sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_x <= i_pixel.pixel_x[XW-1:0];
                r_y <= i_pixel.pixel_y[XW-1:0];
            end
        end
    end

endmodule

FILE: rtl/met_queue.sv
// Short point queue between the front end and the iteration engine.
module met_queue #(
    parameter int DEPTH = met_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  met_pkg::t_point i_data,
    output logic            o_valid,
    input  logic            i_pop,
    output met_pkg::t_point o_data
);
    import met_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_point             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/met_back.sv
// Iteration engine: runs z = z*z + c with the escape test and holds the result beat.
module met_back #(
    parameter int FRAC_BITS = met_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_pop,
    input  met_pkg::t_point               i_point,
    input  logic [met_pkg::COUNT_W-1:0]   i_max_iteration,
    output logic                          o_valid,
    input  logic                          i_ready,
    output met_pkg::t_result              o_result
);
    import met_pkg::*;

    localparam int          MAG_SHIFT = 2 * FRAC_BITS + 2;
    localparam bit          MAG_ON    = (MAG_SHIFT <= 63);
    localparam logic [64:0] MAG_LIMIT = MAG_ON ? (65'd1 << MAG_SHIFT) : 65'd0;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_STEP} t_state;

    t_state                     r_state;
    logic signed [WORD_W-1:0]   r_z_re;
    logic signed [WORD_W-1:0]   r_z_im;
    logic signed [WORD_W-1:0]   r_c_re;
    logic signed [WORD_W-1:0]   r_c_im;
    logic                       r_sat;
    logic [COUNT_W-1:0]         r_n;
    logic signed [63:0]         r_rr;
    logic signed [63:0]         r_ii;
    logic signed [63:0]         r_ri;
    logic                       r_out_valid;
    t_result                    r_out;

    logic [63:0]                mag;
    logic signed [63:0]         diff;
    t_sat                       n_re;
    t_sat                       n_im;
    logic                       esc;
    logic                       limit_hit;
    logic                       finish;
    logic                       out_free;
    logic                       done;

    assign o_pop    = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        mag       = $unsigned(r_rr) + $unsigned(r_ii);
        diff      = r_rr - r_ii;
        n_re      = sat_word(SAT_IN_W'(diff >>> FRAC_BITS) + SAT_IN_W'(r_c_re));
        n_im      = sat_word(SAT_IN_W'(r_ri >>> (FRAC_BITS - 1)) + SAT_IN_W'(r_c_im));
        esc       = MAG_ON && ({1'b0, mag} >= MAG_LIMIT);
        limit_hit = (r_n >= i_max_iteration);
        finish    = limit_hit || r_sat || esc;
        out_free  = !r_out_valid || i_ready;
        done      = (r_state == S_STEP) && finish && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_c_re  <= i_point.c_real;
                        r_c_im  <= i_point.c_imag;
                        r_z_re  <= i_point.c_real;
                        r_z_im  <= i_point.c_imag;
                        r_sat   <= i_point.sat;
                        r_n     <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_rr    <= r_z_re * r_z_re;
                    r_ii    <= r_z_im * r_z_im;
                    r_ri    <= r_z_re * r_z_im;
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (finish) begin
                        if (out_free) begin
                            r_out.iteration_count <= r_n;
                            r_out.inside_set      <= limit_hit && (i_max_iteration != '0);
                            r_state               <= S_IDLE;
                        end
                    end else begin
                        r_z_re  <= n_re.value;
                        r_z_im  <= n_im.value;
                        r_sat   <= n_re.sat || n_im.sat;
                        r_n     <= r_n + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/mandelbrot_escape_time_unit.sv
// Top level of the escape-time unit: configuration registers, front end, queue and engine.
// In each update of a point, S_MUL forms the three 32x32 products and S_STEP
// rescales, saturates and tests them before the next update or the result.
// The result is held in a registered beat until the receiver takes it.
// The front end and queue take further pixel beats while the engine iterates.
// Synchronous active-low reset empties the queue and restores the register defaults.
module mandelbrot_escape_time_unit #(
    parameter int COORD_BITS  = met_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS   = met_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = met_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    met_chan_if.sink       i_pixel,
    met_chan_if.sink       i_cfg,
    met_chan_if.source     o_result
);
    import met_pkg::*;

    t_cfg    cfg;
    logic    front_push;
    logic    q_ready;
    t_point  front_point;
    logic    q_valid;
    logic    q_pop;
    t_point  q_point;
    logic    cfg_ready;
    logic    pixel_ready;
    logic    res_valid;
    t_result res_data;

    assign i_cfg.ready    = cfg_ready;
    assign i_pixel.ready  = pixel_ready;
    assign o_result.valid = res_valid;
    assign o_result.data  = res_data;

    met_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .o_ready (cfg_ready),
        .i_beat  (i_cfg.data),
        .o_cfg   (cfg)
    );

    met_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_pixel.valid),
        .o_ready   (pixel_ready),
        .i_pixel   (i_pixel.data),
        .i_cfg     (cfg),
        .o_push    (front_push),
        .i_q_ready (q_ready),
        .o_point   (front_point)
    );

    met_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .o_ready (q_ready),
        .i_data  (front_point),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_point)
    );

    met_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .o_pop           (q_pop),
        .i_point         (q_point),
        .i_max_iteration (cfg.max_iteration),
        .o_valid         (res_valid),
        .i_ready         (o_result.ready),
        .o_result        (res_data)
    );

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the escape-time unit: bursty pixel driver, stalling result monitor.
module tb_top;
    import met_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int HOLD_LONG = 400;
    localparam int END_PAUSE = 64;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_SELDOM,
        RDY_PATTERN
    } t_rdy_mode;

    logic i_clk;
    logic i_rst_n;

    met_chan_if #(.t_payload(t_pixel))    pixel_ch ();
    met_chan_if #(.t_payload(t_cfg_beat)) cfg_ch ();
    met_chan_if #(.t_payload(t_result))   result_ch ();

    mandelbrot_escape_time_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pixel  (pixel_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    t_pixel    pending_pixels[$];
    t_cfg_beat pending_writes[$];
    t_result   predicted_escapes[$];
    t_cfg      view_cfg;
    t_cfg_beat write_taken;
    t_result   escape_due;

    int        mismatches;
    int        burst_left;
    int        gap_left;
    int        pix_gap_max;
    int        hold_left;
    logic      long_hold_armed;
    logic      long_hold_done;
    t_rdy_mode rdy_mode;
    logic [15:0] stall_pattern;
    int        cur_max;
    longint    cycle_budget;
    longint    cycle_count;

    function automatic logic signed [63:0] clamp_word(input logic signed [63:0] v,
                                                      inout logic sat);
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        logic signed [63:0] r;
        hi = WORD_MAX;
        lo = WORD_MIN;
        r = v;
        if (v > 64'(hi)) begin
            sat = 1'b1;
            r = hi;
        end else if (v < 64'(lo)) begin
            sat = 1'b1;
            r = lo;
        end
        return r;
    endfunction

    // Iteration count and inside flag for one pixel under the given view.
    function automatic t_result escape_time(input t_cfg cfg, input t_pixel px);
        logic signed [31:0] o_re;
        logic signed [31:0] o_im;
        logic signed [31:0] s_re;
        logic signed [31:0] s_im;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] c_re;
        logic signed [63:0] c_im;
        logic signed [63:0] re;
        logic signed [63:0] im;
        logic signed [63:0] sq_re;
        logic signed [63:0] sq_im;
        logic signed [63:0] prod_ri;
        logic signed [63:0] diff;
        logic [63:0]        mag;
        logic               sat;
        int                 n;
        int                 max_it;
        t_result            r;
        o_re = cfg.origin_real;
        o_im = cfg.origin_imag;
        s_re = cfg.step_real;
        s_im = cfg.step_imag;
        x = {52'd0, px.pixel_x};
        y = {52'd0, px.pixel_y};
        max_it = cfg.max_iteration;
        sat = 1'b0;
        c_re = clamp_word(64'(o_re) + x * 64'(s_re), sat);
        c_im = clamp_word(64'(o_im) + y * 64'(s_im), sat);
        re = c_re;
        im = c_im;
        n = 0;
        while (n < max_it) begin
            sq_re = re * re;
            sq_im = im * im;
            mag = sq_re + sq_im;
            if (sat || mag >= (64'd1 << (2 * FRAC + 2)))
                break;
            diff = sq_re - sq_im;
            prod_ri = re * im;
            diff = diff >>> FRAC;
            prod_ri = prod_ri >>> (FRAC - 1);
            re = clamp_word(diff + c_re, sat);
            im = clamp_word(prod_ri + c_im, sat);
            n++;
        end
        r.iteration_count = n[COUNT_W-1:0];
        r.inside_set = (max_it != 0) && (n >= max_it);
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 4 * cycle_budget + 20000) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Configuration driver and the bench's own copy of the registers.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.data  <= '0;
            view_cfg     <= '{RST_MAX_ITERATION, RST_ORIGIN_REAL, RST_ORIGIN_IMAG,
                              RST_STEP_REAL, RST_STEP_IMAG};
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                write_taken = pending_writes.pop_front();
                case (write_taken.index)
                    REG_MAX_ITERATION: view_cfg.max_iteration <= write_taken.value[COUNT_W-1:0];
                    REG_ORIGIN_REAL:   view_cfg.origin_real   <= write_taken.value;
                    REG_ORIGIN_IMAG:   view_cfg.origin_imag   <= write_taken.value;
                    REG_STEP_REAL:     view_cfg.step_real     <= write_taken.value;
                    REG_STEP_IMAG:     view_cfg.step_imag     <= write_taken.value;
                    default: ;
                endcase
            end
            if (pending_writes.size() != 0) begin
                cfg_ch.valid <= 1'b1;
                cfg_ch.data  <= pending_writes[0];
            end else begin
                cfg_ch.valid <= 1'b0;
            end
        end
    end

    // Pixel driver: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pixel_ch.valid <= 1'b0;
            pixel_ch.data  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (pixel_ch.valid && pixel_ch.ready)
                predicted_escapes.push_back(escape_time(view_cfg, pending_pixels.pop_front()));
            if (pixel_ch.valid && !pixel_ch.ready) begin
                // The offered beat stays on the channel until it is taken.
            end else if (gap_left > 0) begin
                gap_left--;
                pixel_ch.valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
                pixel_ch.valid <= 1'b1;
                pixel_ch.data  <= pending_pixels[0];
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left = (pix_gap_max == 0) ? 0 : $urandom_range(0, pix_gap_max);
                end
            end else begin
                pixel_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each beat with the oldest prediction and stalls at will.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            hold_left = 0;
            long_hold_done = 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (predicted_escapes.size() == 0) begin
                    $display("%0t: result beat with nothing predicted: count %0d inside %0b",
                             $time, result_ch.data.iteration_count, result_ch.data.inside_set);
                    mismatches++;
                end else begin
                    escape_due = predicted_escapes.pop_front();
                    if (result_ch.data.iteration_count !== escape_due.iteration_count) begin
                        $display("%0t: iteration_count expected %0d actual %0d", $time,
                                 escape_due.iteration_count, result_ch.data.iteration_count);
                        mismatches++;
                    end
                    if (result_ch.data.inside_set !== escape_due.inside_set) begin
                        $display("%0t: inside_set expected %0b actual %0b", $time,
                                 escape_due.inside_set, result_ch.data.inside_set);
                        mismatches++;
                    end
                end
            end
            if (long_hold_armed && !long_hold_done) begin
                hold_left = HOLD_LONG;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                case (rdy_mode)
                    RDY_ALWAYS:  result_ch.ready <= 1'b1;
                    RDY_MOSTLY:  result_ch.ready <= ($urandom_range(0, 3) != 0);
                    RDY_SELDOM:  result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        result_ch.ready <= stall_pattern[0];
                        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
                    end
                endcase
            end
        end
    end

    task automatic write_reg(input logic [REG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
        t_cfg_beat b;
        b.index = idx;
        b.value = val;
        pending_writes.push_back(b);
    endtask

    task automatic drain_writes();
        while (pending_writes.size() != 0 || cfg_ch.valid)
            @(negedge i_clk);
    endtask

    task automatic load_view(input int max_it, input logic signed [31:0] o_re,
                             input logic signed [31:0] o_im, input logic signed [31:0] s_re,
                             input logic signed [31:0] s_im);
        write_reg(REG_MAX_ITERATION, WORD_W'(max_it));
        write_reg(REG_ORIGIN_REAL, o_re);
        write_reg(REG_ORIGIN_IMAG, o_im);
        write_reg(REG_STEP_REAL, s_re);
        write_reg(REG_STEP_IMAG, s_im);
        drain_writes();
        cur_max = max_it;
        cycle_budget += 1000;
    endtask

    task automatic queue_pixel(input int x, input int y);
        t_pixel p;
        p.pixel_x = x[PIXEL_W-1:0];
        p.pixel_y = y[PIXEL_W-1:0];
        pending_pixels.push_back(p);
        cycle_budget += 2 * cur_max + 100;
    endtask

    task automatic wait_idle();
        while (pending_pixels.size() != 0 || pixel_ch.valid || predicted_escapes.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin : stimulus
        int     win;
        int     items;
        int     max_it;
        longint span;
        longint st_re;
        longint st_im;
        longint org_re;
        longint org_im;

        i_rst_n         = 1'b0;
        pixel_ch.valid  = 1'b0;
        pixel_ch.data   = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        result_ch.ready = 1'b0;
        mismatches      = 0;
        pix_gap_max     = 0;
        rdy_mode        = RDY_ALWAYS;
        stall_pattern   = 16'hB3A5;
        long_hold_armed = 1'b0;
        cur_max         = RST_MAX_ITERATION;
        cycle_budget    = 10000;
        cycle_count     = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Register defaults: the whole view sits at -3.5 and escapes at once.
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(0, 4095);
        queue_pixel(4095, 0);
        queue_pixel(2048, 1);
        wait_idle();

        // A zero limit does no iteration and never reports inside.
        load_view(0, 0, 0, 0, 0);
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        wait_idle();

        // Extreme registers: c saturates, or lands far outside the set.
        load_view(1, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
        for (int idx = int'(REG_STEP_IMAG) + 1; idx < (1 << REG_INDEX_W); idx++)
            write_reg(REG_INDEX_W'(idx), $urandom);
        drain_writes();
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        wait_idle();

        // Full limit on the origin, which never escapes.
        load_view(65535, 0, 0, 0, 0);
        queue_pixel(0, 0);
        wait_idle();

        // Grid of 1/8 from -2: threshold equality, fixed points, cycles and saturation.
        rdy_mode = RDY_MOSTLY;
        pix_gap_max = 5;
        load_view(50, -32'sd536870912, 0, 32'sd33554432, 32'sd33554432);
        queue_pixel(0, 0);
        queue_pixel(16, 0);
        queue_pixel(24, 0);
        queue_pixel(8, 8);
        queue_pixel(18, 4);
        queue_pixel(10, 0);
        queue_pixel(4095, 4095);
        queue_pixel(0, 4095);
        wait_idle();

        // Quick points while the receiver holds off, so that the input backs up.
        rdy_mode = RDY_ALWAYS;
        pix_gap_max = 0;
        load_view(8, -32'sd536870912, -32'sd536870912, 32'sd16777216, 32'sd16777216);
        long_hold_armed = 1'b1;
        cycle_budget += 4 * HOLD_LONG;
        for (int k = 0; k < 60; k++)
            queue_pixel($urandom_range(0, 63), $urandom_range(0, 63));
        wait_idle();

        for (int ph = 0; ph < 9; ph++) begin
            win = $urandom_range(8, 64);
            span = longint'($urandom_range(32'd1 << 27, 32'd1 << 30));
            st_re = span / win;
            st_im = (span * longint'($urandom_range(50, 150))) / (100 * win);
            if ($urandom_range(0, 1)) st_re = -st_re;
            if ($urandom_range(0, 1)) st_im = -st_im;
            org_re = -201326592 + longint'($urandom_range(0, 32'd1 << 29)) - (1 << 28);
            org_im = longint'($urandom_range(0, 32'd1 << 29)) - (1 << 28);
            org_re = org_re - st_re * win / 2;
            org_im = org_im - st_im * win / 2;
            max_it = (ph == 4) ? 2000 : $urandom_range(1, 200);
            items = (ph == 4) ? 12 : 70;
            if (ph == 0) begin
                rdy_mode = RDY_ALWAYS;
                pix_gap_max = 0;
            end else begin
                rdy_mode = t_rdy_mode'($urandom_range(0, 3));
                pix_gap_max = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
                stall_pattern = 16'($urandom) | 16'h0001;
            end
            load_view(max_it, 32'(org_re), 32'(org_im), 32'(st_re), 32'(st_im));
            for (int k = 0; k < items; k++) begin
                if ($urandom_range(0, 99) < 85)
                    queue_pixel($urandom_range(0, win - 1), $urandom_range(0, win - 1));
                else
                    queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
            end
            wait_idle();
        end

        repeat (END_PAUSE) @(negedge i_clk);
        if (mismatches == 0 && predicted_escapes.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: files.f
rtl/met_pkg.sv
rtl/met_chan_if.sv
rtl/met_regs.sv
rtl/met_front.sv
rtl/met_queue.sv
rtl/met_back.sv
rtl/mandelbrot_escape_time_unit.sv
bench/tb_top.sv
